// ===== hw/rtl/jmsp_pkg.sv =====
// Shared constants and types of the JPEG marker segment parser.
package jmsp_pkg;

    localparam int OFFSET_BITS_DEF = 32;

    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_HUNT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEN_HI  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LEN_LO  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PAYLOAD = 2'd3;

    localparam int EV_W = 3;
    localparam logic [EV_W-1:0] EV_HUNT    = 3'd0;
    localparam logic [EV_W-1:0] EV_NOLEN   = 3'd1;
    localparam logic [EV_W-1:0] EV_LEN_HI  = 3'd2;
    localparam logic [EV_W-1:0] EV_HEADER  = 3'd3;
    localparam logic [EV_W-1:0] EV_PAYLOAD = 3'd4;
    localparam logic [EV_W-1:0] EV_LEN_ERR = 3'd5;

    typedef struct packed {
        logic [EV_W-1:0] event_res;
        logic [7:0]      marker_type;
        logic [7:0]      payload_byte;
        logic            payload_last;
        logic [31:0]     segment_start;
        logic [31:0]     data_start;
        logic [15:0]     data_length;
        logic [31:0]     byte_offset;
    } result_t;

endpackage

// ===== hw/rtl/jpeg_marker_segment_parser_top.sv =====
// Top level of the JPEG marker segment parser: handshake and result register.
//
// The parser takes one JPEG stream byte per item and returns exactly one result
// item for each, in the cycle after the byte is accepted. Unless stalled it
// sustains one item per clock cycle: the only feedback is the small parse state
// register, which is updated in the same cycle that a byte is accepted. A result
// register separates the two channels, so a new byte is taken whenever that
// register is empty or its result is being taken in the same cycle; in_stall is
// high only while a result waits and the receiver stalls. Offsets count bytes
// from zero at reset, wrap at OFFSET_BITS bits, and are reported in their low 32
// bits. Bytes inside a segment payload are never scanned for markers, and a
// length field below two reports a length error and drops the segment.
module jpeg_marker_segment_parser_top #(
    parameter int OFFSET_BITS = jmsp_pkg::OFFSET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [7:0]  marker_type,
    output logic [7:0]  payload_byte,
    output logic        payload_last,
    output logic [31:0] segment_start,
    output logic [31:0] data_start,
    output logic [15:0] data_length,
    output logic [31:0] byte_offset
);
    import jmsp_pkg::*;

    logic    in_accept;
    logic    out_valid_reg, out_valid_next;
    result_t core_res;
    result_t res_reg;

    // A byte may enter whenever the result register is free or drains now.
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    jmsp_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (data_byte),
        .res       (core_res)
    );

    always_comb
    begin
        if (in_accept)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result payload carries no reset; it is only looked at while valid.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            res_reg <= core_res;
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = res_reg.event_res;
    assign marker_type   = res_reg.marker_type;
    assign payload_byte  = res_reg.payload_byte;
    assign payload_last  = res_reg.payload_last;
    assign segment_start = res_reg.segment_start;
    assign data_start    = res_reg.data_start;
    assign data_length   = res_reg.data_length;
    assign byte_offset   = res_reg.byte_offset;

endmodule

// ===== hw/rtl/jmsp_core.sv =====
// Parser state registers and the per-byte next-state and result logic.
module jmsp_core #(
    parameter int OFFSET_BITS = jmsp_pkg::OFFSET_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    output jmsp_pkg::result_t res
);
    import jmsp_pkg::*;

    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic                   prefix_reg, prefix_next;
    logic [7:0]             marker_reg, marker_next;
    logic [7:0]             len_hi_reg, len_hi_next;
    logic [15:0]            remain_reg, remain_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] mpos_reg, mpos_next;

    logic [OFFSET_BITS+31:0] pos_ext, next_ext, mpos_ext;
    logic [15:0]             len_full;
    logic [15:0]             remain_dec;

    assign pos_next   = pos_reg + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
    assign pos_ext    = {32'd0, pos_reg};
    assign next_ext   = {32'd0, pos_next};
    assign mpos_ext   = {32'd0, mpos_reg};
    assign len_full   = {len_hi_reg, data_byte};
    assign remain_dec = remain_reg - 16'd1;

    always_comb
    begin
        mode_next          = mode_reg;
        prefix_next        = prefix_reg;
        marker_next        = marker_reg;
        len_hi_next        = len_hi_reg;
        remain_next        = remain_reg;
        mpos_next          = mpos_reg;
        res.event_res      = EV_HUNT;
        res.payload_byte   = 8'd0;
        res.payload_last   = 1'b0;
        res.data_start     = 32'd0;
        res.data_length    = 16'd0;
        case (mode_reg)
            MODE_LEN_HI:
            begin
                len_hi_next   = data_byte;
                res.event_res = EV_LEN_HI;
                mode_next     = MODE_LEN_LO;
            end
            MODE_LEN_LO:
            begin
                prefix_next = 1'b0;
                if (len_full < 16'd2)
                begin
                    res.event_res = EV_LEN_ERR;
                    mode_next     = MODE_HUNT;
                end
                else
                begin
                    res.event_res   = EV_HEADER;
                    remain_next     = len_full - 16'd2;
                    res.data_length = len_full - 16'd2;
                    res.data_start  = next_ext[31:0];
                    mode_next       = (len_full == 16'd2) ? MODE_HUNT : MODE_PAYLOAD;
                end
            end
            MODE_PAYLOAD:
            begin
                res.event_res    = EV_PAYLOAD;
                res.payload_byte = data_byte;
                remain_next      = remain_dec;
                if (remain_dec == 16'd0)
                begin
                    res.payload_last = 1'b1;
                    mode_next        = MODE_HUNT;
                end
            end
            default:
            begin
                mode_next = MODE_HUNT;
                if (!prefix_reg)
                begin
                    if (data_byte == 8'hFF)
                    begin
                        prefix_next = 1'b1;
                        mpos_next   = pos_reg;
                    end
                end
                else if (data_byte == 8'hFF)
                begin
                    // Fill byte: the marker now starts at this later prefix.
                    mpos_next = pos_reg;
                end
                else if (data_byte inside {8'h00, [8'hD0:8'hD7]})
                begin
                    prefix_next = 1'b0;
                end
                else
                begin
                    prefix_next = 1'b0;
                    marker_next = data_byte;
                    if (data_byte inside {8'h01, 8'hD8, 8'hD9})
                    begin
                        res.event_res  = EV_NOLEN;
                        res.data_start = next_ext[31:0];
                    end
                    else
                    begin
                        mode_next = MODE_LEN_HI;
                    end
                end
            end
        endcase
        res.marker_type   = marker_next;
        // The prefix position only moves on quiet bytes, so the stored one applies.
        res.segment_start = (res.event_res != EV_HUNT) ? mpos_ext[31:0] : 32'd0;
        res.byte_offset   = pos_ext[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HUNT;
            prefix_reg <= 1'b0;
            marker_reg <= 8'd0;
            len_hi_reg <= 8'd0;
            remain_reg <= 16'd0;
            pos_reg    <= '0;
            mpos_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            marker_reg <= marker_next;
            len_hi_reg <= len_hi_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            mpos_reg   <= mpos_next;
        end
    end

endmodule

// ===== hw/rtl/jmsp_checker.sv =====
// Port-level assertions for the JPEG marker segment parser and their binding.
module jmsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  event_res,
    input logic [31:0] data_start,
    input logic [31:0] byte_offset
);
    import jmsp_pkg::*;

    logic        out_fire;
    logic        seen_reg;
    logic [2:0]  prev_ev_reg;
    logic [15:0] prev_off_reg;
    logic [15:0] off_inc;

    assign out_fire = out_valid & ~out_stall;
    assign off_inc  = byte_offset[15:0] + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            prev_ev_reg  <= EV_HUNT;
            prev_off_reg <= 16'd0;
        end
        else if (out_fire)
        begin
            seen_reg     <= 1'b1;
            prev_ev_reg  <= event_res;
            prev_off_reg <= byte_offset[15:0];
        end
    end

    // A length high byte is always followed by a header or a length error.
    a_len_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && seen_reg && prev_ev_reg == EV_LEN_HI
            |-> event_res == EV_HEADER || event_res == EV_LEN_ERR)
        else $error("length high byte not followed by header or length error");

    // Successive results cover successive stream bytes.
    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && seen_reg |-> byte_offset[15:0] == prev_off_reg + 16'd1)
        else $error("byte offset did not advance by one");

    // A header names the byte after the length field as first payload byte.
    a_header_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_HEADER |-> data_start[15:0] == off_inc)
        else $error("header data start is not the next byte");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(byte_offset))
        else $error("stalled result changed");

endmodule

bind jpeg_marker_segment_parser_top jmsp_checker u_jmsp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_res   (event_res),
    .data_start  (data_start),
    .byte_offset (byte_offset)
);
